>>> rtl/adaptive_energy_speech_detector_core_macros.svh
// assertion macros for the speech detector
`ifndef ADAPTIVE_ENERGY_SPEECH_DETECTOR_CORE_MACROS_SVH
`define ADAPTIVE_ENERGY_SPEECH_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define AESD_ASSERT_NOW(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define AESD_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/aesd_pkg.sv
// types and constants shared by the speech detector files
`default_nettype none

package aesd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SQ_W     = 31;
	localparam int LEVEL_W  = 40;
	localparam int FORGET_W = 8;
	localparam int ADJ_W    = 16;
	localparam int THR_W    = 24;
	localparam int CFG_W    = 24;
	localparam int IDX_W    = 2;
	localparam int MUL_A_W  = 40;
	localparam int MUL_B_W  = 16;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int DIV_W    = LEVEL_W + FORGET_W;
	localparam int CNT_W    = 6;
	localparam int SQ_SHIFT = 16;
	localparam int Q_FRAC   = 8;

	typedef logic [IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_FORGET    = 2'd0;
	localparam cfg_idx_t REG_ADJUST    = 2'd1;
	localparam cfg_idx_t REG_THRESHOLD = 2'd2;

	localparam logic [FORGET_W-1:0] FORGET_RST = 8'd1;
	localparam logic [ADJ_W-1:0]    ADJUST_RST = 16'd3277;
	localparam logic [THR_W-1:0]    THRESH_RST = 24'd2560;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_NEW,
		ST_SQ_OLD,
		ST_ROOT,
		ST_REC_LO,
		ST_REC_HI,
		ST_MUL_L,
		ST_ADD_L,
		ST_DIV_L,
		ST_MUL_B,
		ST_ADD_B,
		ST_DECIDE,
		ST_WRITE
	} aesd_state_t;

endpackage

`default_nettype wire

>>> rtl/aesd_if.sv
// handshake channels for the speech detector
`default_nettype none

interface aesd_audio_if import aesd_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface aesd_decision_if;
	logic valid;
	logic ready;
	logic speech;

	modport source (output valid, output speech, input ready);
	modport sink   (input valid, input speech, output ready);
endinterface

`default_nettype wire

>>> rtl/aesd_cmpsub.sv
// shared compare and subtract unit used by root and division steps
`default_nettype none

module aesd_cmpsub #(
	parameter int W = 29
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic              ge,
	output logic [W-1:0]      diff
);

	assign ge   = (a >= b);
	assign diff = a - b;

endmodule

`default_nettype wire

>>> rtl/adaptive_energy_speech_detector.sv
// top level of the adaptive energy speech detector
// usage
//   audio: one signed 16-bit sample per word with a restart mark; a word is
//   taken when valid and ready are both high, ready is high only while the
//   sequencer is idle
//   decision: one speech flag per sample word, held in an output register
//   until the receiver takes it
//   cfg_we/cfg_index/cfg_data: register writes, only while the block is idle
// sequence, from accept to next accept
//   warm-up words (fewer than WINDOW-1 samples since restart) only square the
//   samples; the seeding word adds the bit-serial root of ROOT_W bits, ROOT_W =
//   ceil((31 + clog2(WINDOW) + 16) / 2), and the reciprocal multiply for the
//   divide by WINDOW in two halves; a tracking word adds the 48-step divide
//   by forget_factor+1, which shares one compare-subtract unit with the root
// reset
//   window empty, levels zero, registers at their defaults; no clearing pass:
//   window entries not yet rewritten since restart read as zero by fill count
// stall
//   a finished flag waits in the output register; the next word is accepted
//   meanwhile and its result waits at the final step until the register frees
`default_nettype none

`include "adaptive_energy_speech_detector_core_macros.svh"

module adaptive_energy_speech_detector_core import aesd_pkg::*; #(
	parameter int WINDOW = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	aesd_audio_if.sink            audio,
	aesd_decision_if.source       decision,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	// widths that follow from the window length
	localparam int SUM_W  = SQ_W + $clog2(WINDOW);
	localparam int ROOT_W = (SUM_W + SQ_SHIFT + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int UW     = ROOT_W + 2;
	localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SEEN_W = $clog2(WINDOW + 1);
	localparam int REC_SHIFT = ROOT_W + $clog2(WINDOW);
	localparam int REC_W     = PROD_W + MUL_B_W + 1;

	localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(WINDOW);
	localparam logic [SEEN_W-1:0] SEEN_SEED = SEEN_W'(WINDOW - 1);
	localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0]  ROOT_STEPS = CNT_W'(ROOT_W - 1);
	localparam logic [CNT_W-1:0]  DIV_STEPS  = CNT_W'(DIV_W - 1);

	// rounded-up reciprocal of the window length, exact for any root value
	localparam logic [63:0] RECIP =
		((64'd1 << REC_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [MUL_B_W-1:0] RECIP_LO = RECIP[MUL_B_W-1:0];
	localparam logic [MUL_B_W-1:0] RECIP_HI = RECIP[2*MUL_B_W-1:MUL_B_W];

	// configuration registers
	logic [FORGET_W-1:0] forget_q;
	logic [ADJ_W-1:0]    adjust_q;
	logic [THR_W-1:0]    thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forget_q <= FORGET_RST;
			adjust_q <= ADJUST_RST;
			thresh_q <= THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORGET:    forget_q <= cfg_data[FORGET_W-1:0];
				REG_ADJUST:    adjust_q <= cfg_data[ADJ_W-1:0];
				REG_THRESHOLD: thresh_q <= cfg_data[THR_W-1:0];
				default:       ;
			endcase
		end
	end

	// sequencer and window state
	aesd_state_t state_q, state_nx;

	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] rd_q;
	logic [SEEN_W-1:0]   seen_q;
	logic [POS_W-1:0]    wpos_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]     sqnew_q;
	logic [SQ_W-1:0]     sqold_q;
	logic [RAD_W-1:0]    rad_q;
	logic [ROOT_W-1:0]   root_q;
	logic [UW-1:0]       rem_q;
	logic [DIV_W-1:0]    div_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PROD_W-1:0]   prod_q;
	logic [LEVEL_W-1:0]  energy_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [LEVEL_W-1:0]  bg_q;
	logic                flag_q;
	logic                out_valid_q;
	logic                speech_q;

	logic [SAMPLE_W-1:0] hist [WINDOW];

	// control decodes
	logic                in_fire;
	logic                out_free;
	logic                seed;
	logic                tracking;
	logic [UW-1:0]       unit_a;
	logic [UW-1:0]       unit_b;
	logic                unit_ge;
	logic [UW-1:0]       unit_diff;
	logic [UW-1:0]       rem_nx;
	logic [DIV_W-1:0]    div_nx;
	logic [ROOT_W-1:0]   root_nx;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic [REC_W-1:0]    rec_sum;
	logic [LEVEL_W-1:0]  energy_nx;
	logic [SAMPLE_W-1:0] mag_new;
	logic [SAMPLE_W-1:0] mag_old;
	logic [POS_W-1:0]    rd_addr;
	logic [LEVEL_W-1:0]  level_cl;
	logic                e_below;

	assign in_fire  = audio.valid && audio.ready;
	assign out_free = !out_valid_q || decision.ready;
	assign seed     = (seen_q == SEEN_SEED);
	assign tracking = (seen_q >= SEEN_SEED);
	assign e_below  = (energy_q < bg_q);
	assign rd_addr  = audio.restart ? '0 : wpos_q;

	// magnitudes of the new and the leaving sample; the leaving one only
	// counts once the window has filled since the last restart
	assign mag_new = sample_q[SAMPLE_W-1] ? (~sample_q + 1'b1) : sample_q;
	assign mag_old = (seen_q != SEEN_FULL) ? '0 :
		(rd_q[SAMPLE_W-1] ? (~rd_q + 1'b1) : rd_q);

	aesd_cmpsub #(.W(UW)) u_cmpsub (
		.a    (unit_a),
		.b    (unit_b),
		.ge   (unit_ge),
		.diff (unit_diff)
	);

	assign rem_nx  = unit_ge ? unit_diff : unit_a;
	assign div_nx  = {div_q[DIV_W-2:0], unit_ge};
	assign root_nx = {root_q[ROOT_W-2:0], unit_ge};

	// root times reciprocal: upper half now, lower half from the last cycle
	assign mul_p     = mul_a * mul_b;
	assign rec_sum   = {1'b0, mul_p, {MUL_B_W{1'b0}}} + {{(MUL_B_W+1){1'b0}}, prod_q};
	assign energy_nx = LEVEL_W'(rec_sum >> REC_SHIFT);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_fire) state_nx = ST_SQ_NEW;
			ST_SQ_NEW: state_nx = ST_SQ_OLD;
			ST_SQ_OLD: state_nx = tracking ? ST_ROOT : ST_WRITE;
			ST_ROOT:   if (cnt_q == '0) state_nx = ST_REC_LO;
			ST_REC_LO: state_nx = ST_REC_HI;
			ST_REC_HI: state_nx = seed ? ST_WRITE : ST_MUL_L;
			ST_MUL_L:  state_nx = ST_ADD_L;
			ST_ADD_L:  state_nx = ST_DIV_L;
			ST_DIV_L:  if (cnt_q == '0) state_nx = ST_MUL_B;
			ST_MUL_B:  state_nx = ST_ADD_B;
			ST_ADD_B:  state_nx = ST_DECIDE;
			ST_DECIDE: state_nx = ST_WRITE;
			ST_WRITE:  if (out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// operand selection for the shared unit and the multiplier
	always_comb begin
		unit_a = {rem_q[UW-2:0], div_q[DIV_W-1]};
		unit_b = UW'(forget_q) + UW'(1);
		mul_a  = MUL_A_W'(mag_new);
		mul_b  = MUL_B_W'(mag_new);
		unique case (state_q)
			ST_ROOT: begin
				unit_a = {rem_q[UW-3:0], rad_q[RAD_W-1 -: 2]};
				unit_b = {root_q, 2'b01};
			end
			ST_SQ_OLD: begin
				mul_a = MUL_A_W'(mag_old);
				mul_b = mag_old;
			end
			ST_REC_LO: begin
				mul_a = MUL_A_W'(root_q);
				mul_b = RECIP_LO;
			end
			ST_REC_HI: begin
				mul_a = MUL_A_W'(root_q);
				mul_b = RECIP_HI;
			end
			ST_MUL_L: begin
				mul_a = level_q;
				mul_b = MUL_B_W'(forget_q);
			end
			ST_MUL_B: begin
				mul_a = energy_q - bg_q;
				mul_b = adjust_q;
			end
			default: ;
		endcase
	end

	assign level_cl = (level_q < bg_q) ? bg_q : level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= '0;
			wpos_q      <= '0;
			sum_q       <= '0;
			level_q     <= '0;
			bg_q        <= '0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && audio.restart) begin
						seen_q <= '0;
						wpos_q <= '0;
						sum_q  <= '0;
					end
				end
				ST_REC_HI: begin
					if (seed) begin
						bg_q    <= energy_nx;
						level_q <= LEVEL_W'(sqnew_q) << Q_FRAC;
					end
				end
				ST_DIV_L: begin
					if (cnt_q == '0) level_q <= div_nx[LEVEL_W-1:0];
				end
				ST_ADD_B: begin
					if (e_below) bg_q <= energy_q;
					else bg_q <= bg_q + prod_q[PROD_W-1:ADJ_W];
				end
				ST_DECIDE: level_q <= level_cl;
				ST_WRITE: begin
					if (out_free) begin
						sum_q       <= sum_q - SUM_W'(sqold_q) + SUM_W'(sqnew_q);
						wpos_q      <= (wpos_q == POS_LAST) ? '0 : wpos_q + 1'b1;
						if (seen_q != SEEN_FULL) seen_q <= seen_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// output register valid: loaded at the final step, freed when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WRITE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (decision.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= audio.sample;
			rd_q     <= hist[rd_addr];
		end
		unique case (state_q)
			ST_SQ_NEW: sqnew_q <= mul_p[SQ_W-1:0];
			ST_SQ_OLD: begin
				sqold_q <= mul_p[SQ_W-1:0];
				flag_q  <= 1'b1;
				rad_q   <= {{(RAD_W-SUM_W){1'b0}}, sum_q} << SQ_SHIFT;
				rem_q   <= '0;
				root_q  <= '0;
				cnt_q   <= ROOT_STEPS;
			end
			ST_ROOT: begin
				rem_q  <= rem_nx;
				root_q <= root_nx;
				rad_q  <= rad_q << 2;
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_REC_LO: prod_q <= mul_p;
			ST_REC_HI: energy_q <= energy_nx;
			ST_MUL_L: prod_q <= mul_p;
			ST_ADD_L: begin
				div_q <= prod_q[DIV_W-1:0] + DIV_W'(energy_q);
				rem_q <= '0;
				cnt_q <= DIV_STEPS;
			end
			ST_DIV_L: begin
				rem_q <= rem_nx;
				div_q <= div_nx;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_MUL_B: prod_q <= mul_p;
			ST_DECIDE: flag_q <= ((level_cl - bg_q) > LEVEL_W'(thresh_q));
			ST_WRITE: begin
				if (out_free) begin
					hist[wpos_q] <= sample_q;
					speech_q     <= flag_q;
				end
			end
			default: ;
		endcase
	end

	assign audio.ready     = (state_q == ST_IDLE);
	assign decision.valid  = out_valid_q;
	assign decision.speech = speech_q;

	`AESD_ASSERT_NEXT(a_accept_starts, in_fire, state_q == ST_SQ_NEW, "accept did not start work")
	`AESD_ASSERT_NOW(a_seen_bound, 1'b1, seen_q <= SEEN_FULL, "fill count beyond window")
	`AESD_ASSERT_NOW(a_div_rem, state_q == ST_DIV_L, rem_q < UW'(forget_q) + UW'(1), "remainder too big")
	`AESD_ASSERT_NEXT(a_restart_clears, in_fire && audio.restart, seen_q == '0, "restart kept count")
	`AESD_ASSERT_NOW(a_level_floor, state_q == ST_WRITE && tracking && !seed, level_q >= bg_q, "level below background")

endmodule

`default_nettype wire
